// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Simulation builds see the checks;
// synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/kuf_pkg.sv -----
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared constants and the sequencer state type of the union-find edge filter.
// ----------------------------------------------------------------------------
package kuf_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int NODE_W        = 10;
  localparam int WEIGHT_W      = 32;
  localparam int TOTAL_W       = 48;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 10'd1023;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK_A,
    ST_WALK_B,
    ST_LINK,
    ST_DONE
  } kuf_state_t;

endpackage

// ----- sv/kuf_parent_mem.sv -----
// ----------------------------------------------------------------------------
// kuf_parent_mem
// Parent link table: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module kuf_parent_mem #(
  parameter int DEPTH = kuf_pkg::MAX_NODES_DEF,
  parameter int AW    = $clog2(kuf_pkg::MAX_NODES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/kuf_root_walk.sv -----
// ----------------------------------------------------------------------------
// kuf_root_walk
// Root finder: follows one parent link per cycle until a node is its own
// parent or the step bound is reached.
// ----------------------------------------------------------------------------
module kuf_root_walk #(
  parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF,
  parameter int AW        = $clog2(kuf_pkg::MAX_NODES_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] start_node,
  input  logic [AW-1:0] rdata,
  output logic [AW-1:0] raddr,
  output logic          done,
  output logic [AW-1:0] root
);

  logic          active;
  logic [AW-1:0] cur;
  logic [AW-1:0] steps;
  logic          is_root;
  logic          at_bound;

  assign is_root  = (rdata == cur);
  assign at_bound = (steps == AW'(MAX_NODES - 1));
  assign done     = active && (is_root || at_bound);
  assign root     = is_root ? cur : rdata;

  // The next link to follow is the parent just read back, or the start node when a walk starts.
  always_comb begin
    if (start) begin
      raddr = start_node;
    end else begin
      raddr = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur   <= start_node;
      steps <= '0;
    end else if (active && !done) begin
      cur   <= rdata;
      steps <= steps + 1'b1;
    end
  end

endmodule

// ----- sv/kuf_sat_add.sv -----
// ----------------------------------------------------------------------------
// kuf_sat_add
// Saturating signed adder for the running tree weight.
// ----------------------------------------------------------------------------
module kuf_sat_add (
  input  logic signed [kuf_pkg::TOTAL_W-1:0]  total,
  input  logic signed [kuf_pkg::WEIGHT_W-1:0] weight,
  output logic signed [kuf_pkg::TOTAL_W-1:0]  sum,
  output logic                                clamped
);

  localparam int TW = kuf_pkg::TOTAL_W;

  logic signed [TW:0] wide;

  assign wide = {total[TW-1], total} + (TW+1)'(weight);

  // The sum overflowed when its two top bits disagree.
  always_comb begin
    clamped = (wide[TW] != wide[TW-1]);
    if (!clamped) begin
      sum = wide[TW-1:0];
    end else if (wide[TW]) begin
      sum = {1'b1, {(TW-1){1'b0}}};
    end else begin
      sum = {1'b0, {(TW-1){1'b1}}};
    end
  end

endmodule

// ----- sv/kruskal_union_find_edge_filter_unit.sv -----
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_unit
// Kruskal spanning-tree edge filter over a quick-union parent table.
// ----------------------------------------------------------------------------
// Edges arrive already sorted by ascending weight, one word at a time, and
// each edge produces exactly one result word. The block handles one edge at
// a time and holds in_stall high while it works. For an edge with both
// endpoints in range, the single parent-table read port follows one link
// per cycle, from node_a to its root and then from node_b to its root; the
// link state then joins the two roots if they differ, and the done state
// loads the result word once the output register is free. A root walk is
// cut off when its step counter reaches MAX_NODES - 1. An edge with a bad
// endpoint skips both walks. An edge with start_new set first rebuilds the
// table with one write per cycle. The same clearing pass runs after reset,
// during which no edge is taken; the configuration port is always ready. A
// finished result waits in the output register, and the next edge can be
// taken while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kruskal_union_find_edge_filter_unit #(
  parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration: node_count.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kuf_pkg::NODE_W-1:0]          cfg_data,
  // Edge input.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kuf_pkg::NODE_W-1:0]          node_a,
  input  logic [kuf_pkg::NODE_W-1:0]          node_b,
  input  logic signed [kuf_pkg::WEIGHT_W-1:0] weight,
  input  logic                                start_new,
  input  logic                                last_edge,
  // Result output.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                accepted,
  output logic signed [kuf_pkg::TOTAL_W-1:0]  total_cost,
  output logic                                bad_node,
  output logic                                saturated,
  output logic                                final_res
);

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  kuf_pkg::kuf_state_t state, state_next;

  logic [kuf_pkg::NODE_W-1:0]          node_count;
  logic [kuf_pkg::NODE_W-1:0]          item_a;
  logic [kuf_pkg::NODE_W-1:0]          item_b;
  logic signed [kuf_pkg::WEIGHT_W-1:0] item_w;
  logic                                item_last;
  logic                                clear_resume;
  logic [NW-1:0]                       clr_idx;
  logic                                clr_last;
  logic [NW-1:0]                       root_a;
  logic signed [kuf_pkg::TOTAL_W-1:0]  total;
  logic                                sat;
  logic                                acc_r;
  logic                                bad_r;

  logic                                in_take;
  logic                                item_bad;
  logic                                joins;
  logic                                out_free;

  logic                                mem_we;
  logic [NW-1:0]                       mem_waddr;
  logic [NW-1:0]                       mem_wdata;
  logic [NW-1:0]                       mem_raddr;
  logic [NW-1:0]                       mem_rdata;

  logic                                walk_start;
  logic [NW-1:0]                       walk_node;
  logic                                walk_done;
  logic [NW-1:0]                       walk_root;

  logic signed [kuf_pkg::TOTAL_W-1:0]  sum;
  logic                                clamped;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign clr_last  = (clr_idx == NW'(MAX_NODES - 1));
  assign out_free  = !out_valid || !out_stall;

  // An endpoint must lie in 1..node_count and inside the table.
  assign item_bad = (item_a == '0) || (item_b == '0) ||
                    (item_a > node_count) || (item_b > node_count) ||
                    (32'(item_a) >= MAX_NODES) || (32'(item_b) >= MAX_NODES);

  // The edge joins two components when the two roots differ.
  assign joins = (root_a != walk_root);

  kuf_parent_mem #(
    .DEPTH (MAX_NODES),
    .AW    (NW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kuf_root_walk #(
    .MAX_NODES (MAX_NODES),
    .AW        (NW)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (walk_start),
    .start_node (walk_node),
    .rdata      (mem_rdata),
    .raddr      (mem_raddr),
    .done       (walk_done),
    .root       (walk_root)
  );

  kuf_sat_add u_add (
    .total   (total),
    .weight  (item_w),
    .sum     (sum),
    .clamped (clamped)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      kuf_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = clear_resume ? kuf_pkg::ST_CHECK : kuf_pkg::ST_IDLE;
        end
      end
      kuf_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = start_new ? kuf_pkg::ST_CLEAR : kuf_pkg::ST_CHECK;
        end
      end
      kuf_pkg::ST_CHECK: begin
        state_next = item_bad ? kuf_pkg::ST_DONE : kuf_pkg::ST_WALK_A;
      end
      kuf_pkg::ST_WALK_A: begin
        if (walk_done) begin
          state_next = kuf_pkg::ST_WALK_B;
        end
      end
      kuf_pkg::ST_WALK_B: begin
        if (walk_done) begin
          state_next = kuf_pkg::ST_LINK;
        end
      end
      kuf_pkg::ST_LINK: begin
        state_next = kuf_pkg::ST_DONE;
      end
      kuf_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = kuf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kuf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer. The table write port is shared by
  // the clearing pass and the link write.
  always_comb begin
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = clr_idx;
    mem_wdata  = clr_idx;
    walk_start = 1'b0;
    walk_node  = NW'(item_a);
    case (state)
      kuf_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      kuf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      kuf_pkg::ST_CHECK: begin
        walk_start = !item_bad;
      end
      kuf_pkg::ST_WALK_A: begin
        walk_start = walk_done;
        walk_node  = NW'(item_b);
      end
      kuf_pkg::ST_LINK: begin
        mem_we    = joins;
        mem_waddr = root_a;
        mem_wdata = walk_root;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kuf_pkg::ST_CLEAR;
      clr_idx      <= '0;
      clear_resume <= 1'b0;
      node_count   <= kuf_pkg::NODE_COUNT_RESET;
      total        <= '0;
      sat          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if (state == kuf_pkg::ST_CLEAR) begin
        clr_idx <= clr_last ? '0 : clr_idx + 1'b1;
      end
      if (in_take) begin
        clear_resume <= 1'b1;
        if (start_new) begin
          total <= '0;
          sat   <= 1'b0;
        end
      end
      if (state == kuf_pkg::ST_LINK && joins) begin
        total <= sum;
        if (clamped) begin
          sat <= 1'b1;
        end
      end
      if (state == kuf_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Edge and result payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_a    <= node_a;
      item_b    <= node_b;
      item_w    <= weight;
      item_last <= last_edge;
    end
    if (state == kuf_pkg::ST_CHECK) begin
      bad_r <= item_bad;
      acc_r <= 1'b0;
    end
    if (state == kuf_pkg::ST_WALK_A && walk_done) begin
      root_a <= walk_root;
    end
    if (state == kuf_pkg::ST_LINK) begin
      acc_r <= joins;
    end
    if (state == kuf_pkg::ST_DONE && out_free) begin
      accepted   <= acc_r;
      total_cost <= total;
      bad_node   <= bad_r;
      saturated  <= sat;
      final_res  <= item_last;
    end
  end

  // A reset always empties the output register.
  `ASSERT_ALWAYS(a_rst_out_empty, clk, rst |=> !out_valid, "output valid after reset")
  // An edge with a bad endpoint never enters the tree.
  `ASSERT_RST(a_bad_not_acc, clk, rst, out_valid |-> !(accepted && bad_node), "bad edge accepted")
  // The parent table is written only by the clearing pass or a link.
  `ASSERT_RST(a_we_src, clk, rst, mem_we |-> (state == kuf_pkg::ST_CLEAR || state == kuf_pkg::ST_LINK), "stray table write")
  // A start_new edge rebuilds the forest before anything else.
  `ASSERT_RST(a_start_clears, clk, rst, (in_take && start_new) |=> (state == kuf_pkg::ST_CLEAR && clr_idx == '0), "start_new skipped clear")

endmodule

// ----- verif/tb_kruskal_union_find_edge_filter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_kruskal_union_find_edge_filter_unit
// Self-checking bench for the quick-union spanning-tree edge filter. A small
// forest tracker mirrors the parent table, the running tree weight and the
// clamp flag, predicts one verdict word per edge taken and checks every
// result word against the oldest prediction. Directed edges come first, then
// random graph phases under several node counts with random idling on both
// channels outside the one calm phase.
// ----------------------------------------------------------------------------
module tb_kruskal_union_find_edge_filter_unit;

  localparam int TREE_SLOTS  = kuf_pkg::MAX_NODES_DEF;
  // The longest correct quiet spell is a table rebuild plus two full-depth
  // root walks; the watchdog limit lies well above it.
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [kuf_pkg::TOTAL_W:0] SUM_HI =
    {2'b00, {(kuf_pkg::TOTAL_W-1){1'b1}}};
  localparam logic signed [kuf_pkg::TOTAL_W:0] SUM_LO =
    {2'b11, {(kuf_pkg::TOTAL_W-1){1'b0}}};

  // One result word, in port order.
  typedef struct packed {
    logic                               accepted;
    logic signed [kuf_pkg::TOTAL_W-1:0] total;
    logic                               bad;
    logic                               sat;
    logic                               fin;
  } edge_verdict_t;

  // Tracks the forest the block should be holding and the verdict words
  // that are still owed.
  class spanning_forest_tracker;
    logic [kuf_pkg::NODE_W-1:0]         link_of [TREE_SLOTS];
    logic signed [kuf_pkg::TOTAL_W-1:0] tree_weight;
    logic                               clamped;
    logic [kuf_pkg::NODE_W-1:0]         top_node;
    edge_verdict_t                      verdicts_due[$];
    int                                 errors;

    function new();
      rebuild();
      tree_weight = '0;
      clamped     = 1'b0;
      top_node    = kuf_pkg::NODE_COUNT_RESET;
      errors      = 0;
    endfunction

    function void rebuild();
      for (int k = 0; k < TREE_SLOTS; k++) link_of[k] = kuf_pkg::NODE_W'(k);
    endfunction

    function bit in_use(logic [kuf_pkg::NODE_W-1:0] n);
      return n >= 1 && n <= top_node && int'(n) < TREE_SLOTS;
    endfunction

    // Follows parent links, bounded by the table size like the hardware.
    function logic [kuf_pkg::NODE_W-1:0] root_of(logic [kuf_pkg::NODE_W-1:0] n);
      logic [kuf_pkg::NODE_W-1:0] up;
      for (int steps = 0; steps < TREE_SLOTS; steps++) begin
        up = link_of[n];
        if (up == n) break;
        n = up;
      end
      return n;
    endfunction

    function void note_edge(logic [kuf_pkg::NODE_W-1:0] a, logic [kuf_pkg::NODE_W-1:0] b,
                            logic signed [kuf_pkg::WEIGHT_W-1:0] w, logic fresh,
                            logic fin);
      edge_verdict_t                    v;
      logic [kuf_pkg::NODE_W-1:0]       ra;
      logic [kuf_pkg::NODE_W-1:0]       rb;
      logic signed [kuf_pkg::TOTAL_W:0] sum;
      if (fresh) begin
        rebuild();
        tree_weight = '0;
        clamped     = 1'b0;
      end
      v     = '0;
      v.fin = fin;
      if (!in_use(a) || !in_use(b)) begin
        v.bad = 1'b1;
      end else begin
        ra = root_of(a);
        rb = root_of(b);
        if (ra != rb) begin
          sum = tree_weight + w;
          if (sum > SUM_HI) begin
            sum     = SUM_HI;
            clamped = 1'b1;
          end else if (sum < SUM_LO) begin
            sum     = SUM_LO;
            clamped = 1'b1;
          end
          tree_weight = sum[kuf_pkg::TOTAL_W-1:0];
          link_of[ra] = rb;
          v.accepted  = 1'b1;
        end
      end
      v.total = tree_weight;
      v.sat   = clamped;
      verdicts_due.push_back(v);
    endfunction

    function void compare(string field, logic [kuf_pkg::TOTAL_W-1:0] want,
                          logic [kuf_pkg::TOTAL_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(edge_verdict_t got);
      edge_verdict_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: result word with no edge outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = verdicts_due.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("total_cost", want.total, got.total);
      compare("bad_node", want.bad, got.bad);
      compare("saturated", want.sat, got.sat);
      compare("final_res", want.fin, got.fin);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [kuf_pkg::NODE_W-1:0]          cfg_data  = kuf_pkg::NODE_COUNT_RESET;

  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic [kuf_pkg::NODE_W-1:0]          node_a    = '0;
  logic [kuf_pkg::NODE_W-1:0]          node_b    = '0;
  logic signed [kuf_pkg::WEIGHT_W-1:0] weight    = '0;
  logic                                start_new = 1'b0;
  logic                                last_edge = 1'b0;

  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                accepted;
  logic signed [kuf_pkg::TOTAL_W-1:0]  total_cost;
  logic                                bad_node;
  logic                                saturated;
  logic                                final_res;

  // When calm is set neither side idles at random: the sender inserts no idle cycles and the receiver never stalls.
  bit calm = 1'b0;
  int quiet_cycles = 0;
  spanning_forest_tracker board;

  kruskal_union_find_edge_filter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .node_a     (node_a),
    .node_b     (node_b),
    .weight     (weight),
    .start_new  (start_new),
    .last_edge  (last_edge),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .total_cost (total_cost),
    .bad_node   (bad_node),
    .saturated  (saturated),
    .final_res  (final_res)
  );

  always #1 clk = ~clk;

  // Receiver side. Every rising edge of the clock it picks a fresh stall value,
  // checks the result word taken at this edge, and runs the watchdog that
  // counts cycles in which no word moves on any channel. All values read
  // here are the ones sampled at the edge, since the bench drives with
  // nonblocking assignments.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 35);
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_result({accepted, total_cost, bad_node, saturated, final_res});
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("kruskal_union_find_edge_filter_unit regression: fail");
          $finish;
        end
      end
    end
  end

  // Presents one edge word, holds it while the block stalls, and hands it
  // to the tracker at the edge where it is taken. Idle cycles are inserted
  // in front of the word at random unless the phase is calm.
  task automatic send_edge(input logic [kuf_pkg::NODE_W-1:0] a,
                           input logic [kuf_pkg::NODE_W-1:0] b,
                           input logic signed [kuf_pkg::WEIGHT_W-1:0] w,
                           input logic fresh, input logic fin);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    node_a    <= a;
    node_b    <= b;
    weight    <= w;
    start_new <= fresh;
    last_edge <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_edge(a, b, w, fresh, fin);
  endtask

  // Holds the sender back until every owed verdict word has arrived. The
  // queue is looked at on the falling edge, away from the receiver's
  // updates, and driving resumes on the next rising edge.
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // The configuration port carries node_count only; the tracker takes the
  // new value at the edge where the word is written.
  task automatic write_node_count(input logic [kuf_pkg::NODE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.top_node = value;
    cfg_valid <= 1'b0;
  endtask

  // Most picks are in-range nodes; the rest are any 10-bit number, which
  // covers zero and nodes above the count.
  function automatic logic [kuf_pkg::NODE_W-1:0] pick_node(
      input logic [kuf_pkg::NODE_W-1:0] nc);
    if (nc != 0 && $urandom_range(99) < 90) begin
      return kuf_pkg::NODE_W'($urandom_range(1, nc));
    end
    return kuf_pkg::NODE_W'($urandom);
  endfunction

  // A random phase: set the node count, then send whole graphs. A graph
  // opens with start_new, carries ascending weights and closes with
  // last_edge. Some graphs are chains, which build deep parent paths and
  // long root walks. The first graph of a phase may keep the old forest, so
  // that links stored under another node count get walked. About one word
  // in ten is noise with random fields, and now and then the sender waits
  // for every owed result before going on.
  task automatic random_phase(input logic [kuf_pkg::NODE_W-1:0] nc, input bit quiet,
                              input int quota);
    int                                  sent;
    int                                  glen;
    int                                  k;
    int                                  stride;
    int                                  base;
    bit                                  chain;
    bit                                  keep_forest;
    longint                              wt;
    logic signed [kuf_pkg::WEIGHT_W-1:0] w;
    logic [kuf_pkg::NODE_W-1:0]          a;
    logic [kuf_pkg::NODE_W-1:0]          b;
    drain_verdicts();
    write_node_count(nc);
    calm        = quiet;
    sent        = 0;
    keep_forest = 1'($urandom_range(1));
    while (sent < quota) begin
      chain = (nc != 0) && ($urandom_range(99) < 20);
      glen  = chain ? $urandom_range(10, 40) : $urandom_range(3, 20);
      base  = (nc != 0) ? $urandom_range(1, nc) : 0;
      w     = $urandom;
      wt    = w;
      case ($urandom_range(2))
        0: begin
          stride = 3;
        end
        1: begin
          stride = 5000;
        end
        default: begin
          stride = 1 << 26;
        end
      endcase
      for (k = 0; k < glen && sent < quota; k++) begin
        if ($urandom_range(99) < 10) begin
          w = $urandom;
          send_edge(kuf_pkg::NODE_W'($urandom), kuf_pkg::NODE_W'($urandom), w,
                    $urandom_range(7) == 0, 1'($urandom_range(1)));
        end else begin
          if (chain) begin
            a = kuf_pkg::NODE_W'((base + k - 1) % int'(nc) + 1);
            b = kuf_pkg::NODE_W'((base + k) % int'(nc) + 1);
          end else begin
            a = pick_node(nc);
            b = pick_node(nc);
          end
          wt = wt + $urandom_range(stride);
          if (wt > 64'sd2147483647) wt = 64'sd2147483647;
          w = kuf_pkg::WEIGHT_W'(wt);
          send_edge(a, b, w, k == 0 && !keep_forest, k == glen - 1);
        end
        sent++;
        if ($urandom_range(99) < 4) drain_verdicts();
      end
      keep_forest = 1'b0;
    end
    calm = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed edges under the reset node count of 1023. The first opens a
    // graph; then a repeated edge and a self loop are refused, and a zero
    // endpoint on either side is flagged as a bad node.
    send_edge(10'd1, 10'd2, 32'sd5, 1'b1, 1'b0);
    send_edge(10'd2, 10'd1, 32'sd6, 1'b0, 1'b0);
    send_edge(10'd3, 10'd3, 32'sd7, 1'b0, 1'b0);
    send_edge(10'd0, 10'd5, 32'sd7, 1'b0, 1'b0);
    send_edge(10'd5, 10'd0, 32'sd7, 1'b0, 1'b0);
    // The highest node joins the tree, after which it is already connected.
    send_edge(10'd1023, 10'd1, 32'sd8, 1'b0, 1'b0);
    send_edge(10'd1023, 10'd2, 32'sd9, 1'b0, 1'b0);
    // Weight extremes. The 48-bit total cannot reach its clamp limits within
    // one forest of at most 1022 links, so saturated must stay low.
    send_edge(10'd4, 10'd5, 32'sh7fffffff, 1'b0, 1'b0);
    send_edge(10'd6, 10'd7, 32'sh80000000, 1'b0, 1'b0);
    send_edge(10'd1022, 10'd1023, -32'sd1, 1'b0, 1'b1);

    // Smallest node count: only node 1 exists, so its self loop is a valid
    // but refused edge and node 2 is bad.
    drain_verdicts();
    write_node_count(10'd1);
    send_edge(10'd1, 10'd1, 32'sd1, 1'b1, 1'b0);
    send_edge(10'd1, 10'd2, 32'sd2, 1'b0, 1'b0);
    send_edge(10'd2, 10'd1, 32'sd3, 1'b0, 1'b1);

    // A node count of zero makes every node bad.
    drain_verdicts();
    write_node_count(10'd0);
    send_edge(10'd1, 10'd1, 32'sd1, 1'b1, 1'b0);
    send_edge(10'd0, 10'd0, 32'sd2, 1'b0, 1'b1);

    // Build a short chain, then shrink the node count in the middle of the
    // graph: stored links stay and are still followed.
    drain_verdicts();
    write_node_count(10'd1023);
    send_edge(10'd1, 10'd2, 32'sd10, 1'b1, 1'b0);
    send_edge(10'd2, 10'd3, 32'sd11, 1'b0, 1'b0);
    send_edge(10'd3, 10'd4, 32'sd12, 1'b0, 1'b0);
    drain_verdicts();
    write_node_count(10'd3);
    send_edge(10'd1, 10'd4, 32'sd13, 1'b0, 1'b0);
    send_edge(10'd1, 10'd3, 32'sd14, 1'b0, 1'b0);
    send_edge(10'd1023, 10'd1, 32'sd15, 1'b0, 1'b0);
    drain_verdicts();
    write_node_count(10'd1023);
    send_edge(10'd4, 10'd1000, 32'sd16, 1'b0, 1'b1);
    send_edge(10'd1023, 10'd1022, 32'sd0, 1'b1, 1'b1);

    // Random graphs under several node counts; the second phase runs with
    // no idling on either side.
    random_phase(10'd1023, 1'b0, 70);
    random_phase(kuf_pkg::NODE_W'($urandom_range(2, 1023)), 1'b1, 50);
    random_phase(10'd12, 1'b0, 50);
    random_phase(10'd1, 1'b0, 15);
    random_phase(10'd0, 1'b0, 10);
    random_phase(kuf_pkg::NODE_W'($urandom_range(2, 40)), 1'b0, 45);
    random_phase(10'd1023, 1'b0, 50);

    drain_verdicts();
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.verdicts_due.size() == 0) begin
      $display("kruskal_union_find_edge_filter_unit regression: pass");
    end else begin
      $display("kruskal_union_find_edge_filter_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/kuf_pkg.sv
sv/kuf_parent_mem.sv
sv/kuf_root_walk.sv
sv/kuf_sat_add.sv
sv/kruskal_union_find_edge_filter_unit.sv
verif/tb_kruskal_union_find_edge_filter_unit.sv
